// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the touch gesture detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TGD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define TGD_ASSERT(lbl, prop, msg) \
  `TGD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/tgd_pkg.sv =====
// Types, register codes and constants of the touch gesture detector.
package tgd_pkg;

  // Field widths
  localparam int unsigned ReadingW  = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned MsW       = 16;
  localparam int unsigned PctW      = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Calibration accumulator and reciprocal widths (reciprocal stays below 2^25 + 1
  // for any sample count from 1 to 256)
  localparam int unsigned CalSumW   = 24;
  localparam int unsigned CalRecipW = 26;

  localparam int unsigned CalSamplesDefault = 16;

  // Register reset values
  localparam logic [PctW-1:0] ThresholdPctReset = 7'd80;
  localparam logic [MsW-1:0]  DebounceReset     = 16'd50;
  localparam logic [MsW-1:0]  LongPressReset    = 16'd800;
  localparam logic [MsW-1:0]  DoubleTapReset    = 16'd300;

  // Threshold scale: touched when reading < baseline * percent / PctScale
  localparam logic [7:0] PctScale = 8'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThresholdPct = 2'd0,
    CfgDebounceMs   = 2'd1,
    CfgLongPressMs  = 2'd2,
    CfgDoubleTapMs  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ReqSample = 1'b0,
    ReqRecal  = 1'b1
  } req_e;

  typedef struct packed {
    logic [PctW-1:0] threshold_pct;
    logic [MsW-1:0]  debounce_ms;
    logic [MsW-1:0]  long_press_ms;
    logic [MsW-1:0]  double_tap_ms;
  } cfg_t;

  typedef struct packed {
    logic                req_type;
    logic [ReadingW-1:0] raw_reading;
    logic [TimeW-1:0]    now_ms;
  } item_t;

  typedef struct packed {
    logic                tap_event;
    logic                double_tap_event;
    logic                long_press_event;
    logic                touched_now;
    logic                calibrating_now;
    logic [ReadingW-1:0] baseline_out;
  } result_t;

endpackage

// ===== rtl/tgd_cfg_regs.sv =====
// Configuration register file of the touch gesture detector.
module tgd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgd_pkg::CfgDataW-1:0]  cfg_data_i,
  output tgd_pkg::cfg_t                 cfg_o
);

  tgd_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tgd_pkg::cfg_idx_e'(cfg_index_i))
        tgd_pkg::CfgThresholdPct: cfg_d.threshold_pct = cfg_data_i[tgd_pkg::PctW-1:0];
        tgd_pkg::CfgDebounceMs:   cfg_d.debounce_ms   = cfg_data_i;
        tgd_pkg::CfgLongPressMs:  cfg_d.long_press_ms = cfg_data_i;
        tgd_pkg::CfgDoubleTapMs:  cfg_d.double_tap_ms = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_pct <= tgd_pkg::ThresholdPctReset;
      cfg_q.debounce_ms   <= tgd_pkg::DebounceReset;
      cfg_q.long_press_ms <= tgd_pkg::LongPressReset;
      cfg_q.double_tap_ms <= tgd_pkg::DoubleTapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tgd_core.sv =====
// Calibration, baseline tracking and gesture timing for one item per cycle while fire_i is high.
module tgd_core #(
  parameter int unsigned CAL_SAMPLES = tgd_pkg::CalSamplesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  tgd_pkg::item_t  item_i,
  input  tgd_pkg::cfg_t   cfg_i,
  output tgd_pkg::result_t result_o
);

  localparam int unsigned CntW     = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned CalShift = tgd_pkg::CalSumW + $clog2(CAL_SAMPLES);
  localparam int unsigned ProdW    = tgd_pkg::CalSumW + tgd_pkg::CalRecipW;
  localparam int unsigned ThrW     = tgd_pkg::ReadingW + tgd_pkg::PctW;
  // ceil(2^CalShift / CAL_SAMPLES): exact floor division for every 24-bit sum
  localparam logic [tgd_pkg::CalRecipW-1:0] CalRecip = tgd_pkg::CalRecipW'(
      ((64'd1 << CalShift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [CntW-1:0] CalLast = CntW'(CAL_SAMPLES - 1);

  // Gesture and calibration state
  logic                            pressing_q, pressing_d;
  logic                            tap_pending_q, tap_pending_d;
  logic                            long_fired_q, long_fired_d;
  logic                            cal_active_q, cal_active_d;
  logic [CntW-1:0]                 cal_count_q, cal_count_d;
  logic [tgd_pkg::CalSumW-1:0]     cal_sum_q, cal_sum_d;
  logic [tgd_pkg::ReadingW-1:0]    baseline_q, baseline_d;
  logic [tgd_pkg::PctW-1:0]        pct_q, pct_d;
  logic [tgd_pkg::TimeW-1:0]       press_start_q, press_start_d;
  logic [tgd_pkg::TimeW-1:0]       tap_time_q, tap_time_d;

  logic [tgd_pkg::ReadingW-1:0]    rd;
  logic [tgd_pkg::TimeW-1:0]       now;
  logic [tgd_pkg::CalSumW-1:0]     sum_next;
  logic [ProdW-1:0]                cal_prod;
  logic [ThrW-1:0]                 thr_prod;
  logic [ThrW:0]                   rd_scaled;
  logic                            touched;
  logic signed [tgd_pkg::ReadingW:0] delta, step, drift;
  logic [tgd_pkg::TimeW-1:0]       since_tap, held;
  logic [tgd_pkg::TimeW-1:0]       dtap_w, long_w, deb_w;
  logic                            tap_expired;
  tgd_pkg::result_t                res;

  assign rd  = item_i.raw_reading;
  assign now = item_i.now_ms;

  // Calibration average via reciprocal multiply
  assign sum_next = cal_sum_q + tgd_pkg::CalSumW'(rd);
  assign cal_prod = ProdW'(sum_next) * ProdW'(CalRecip);

  // Touch test without a divider: rd < floor(b*p/100) <=> 100*(rd+1) <= b*p;
  // a full-scale reading never passes the saturated threshold
  assign thr_prod  = ThrW'(baseline_q) * ThrW'(pct_q);
  assign rd_scaled = (ThrW + 1)'({1'b0, rd} + 17'd1) * (ThrW + 1)'(tgd_pkg::PctScale);
  assign touched   = (rd != '1) && (rd_scaled <= {1'b0, thr_prod});

  // Drift step, signed division by 16 truncated toward zero
  assign delta = $signed({1'b0, rd}) - $signed({1'b0, baseline_q});
  assign step  = delta[tgd_pkg::ReadingW] ? ((delta + 17'sd15) >>> 4) : (delta >>> 4);
  assign drift = $signed({1'b0, baseline_q}) + step;

  // Elapsed times, modulo 2^32
  assign since_tap   = now - tap_time_q;
  assign held        = now - press_start_q;
  assign dtap_w      = tgd_pkg::TimeW'(cfg_i.double_tap_ms);
  assign long_w      = tgd_pkg::TimeW'(cfg_i.long_press_ms);
  assign deb_w       = tgd_pkg::TimeW'(cfg_i.debounce_ms);
  assign tap_expired = since_tap > dtap_w;

  // Next state and result for the item in the input register
  always_comb begin
    pressing_d    = pressing_q;
    tap_pending_d = tap_pending_q;
    long_fired_d  = long_fired_q;
    cal_active_d  = cal_active_q;
    cal_count_d   = cal_count_q;
    cal_sum_d     = cal_sum_q;
    baseline_d    = baseline_q;
    pct_d         = pct_q;
    press_start_d = press_start_q;
    tap_time_d    = tap_time_q;
    res           = '0;

    if (item_i.req_type == tgd_pkg::ReqRecal) begin
      pressing_d    = 1'b0;
      press_start_d = '0;
      tap_pending_d = 1'b0;
      tap_time_d    = '0;
      long_fired_d  = 1'b0;
      cal_active_d  = 1'b1;
      cal_count_d   = '0;
      cal_sum_d     = '0;
    end else if (cal_active_q) begin
      // Accumulate; at the last sample latch the average
      if (cal_count_q == CalLast) begin
        baseline_d   = cal_prod[CalShift +: tgd_pkg::ReadingW];
        pct_d        = cfg_i.threshold_pct;
        cal_active_d = 1'b0;
        cal_count_d  = '0;
        cal_sum_d    = '0;
      end else begin
        cal_count_d = cal_count_q + CntW'(1);
        cal_sum_d   = sum_next;
      end
    end else begin
      res.touched_now = touched;

      // Pending single tap whose window ran out
      if (tap_pending_q && !touched && tap_expired) begin
        res.tap_event = 1'b1;
        tap_pending_d = 1'b0;
      end

      if (!pressing_q) begin
        if (touched) begin
          pressing_d    = 1'b1;
          press_start_d = now;
        end else begin
          baseline_d = drift[tgd_pkg::ReadingW-1:0];
          pct_d      = cfg_i.threshold_pct;
        end
      end else if (!touched) begin
        // Release
        priority if (long_fired_q) begin
          long_fired_d = 1'b0;
        end else if (held >= long_w) begin
          res.long_press_event = 1'b1;
          tap_pending_d        = 1'b0;
        end else if (held >= deb_w) begin
          if (tap_pending_q && !tap_expired) begin
            res.double_tap_event = 1'b1;
            tap_pending_d        = 1'b0;
          end else begin
            tap_pending_d = 1'b1;
            tap_time_d    = now;
          end
        end else begin
          // Bounce: too short to count
          tap_pending_d = tap_pending_d;
        end
        pressing_d = 1'b0;
      end else if (held >= long_w && !long_fired_q) begin
        // Long press reached while held
        res.long_press_event = 1'b1;
        long_fired_d         = 1'b1;
        tap_pending_d        = 1'b0;
      end
    end

    res.calibrating_now = cal_active_d;
    res.baseline_out    = baseline_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressing_q    <= 1'b0;
      tap_pending_q <= 1'b0;
      long_fired_q  <= 1'b0;
      cal_active_q  <= 1'b1;
      cal_count_q   <= '0;
      cal_sum_q     <= '0;
      baseline_q    <= '0;
      pct_q         <= tgd_pkg::ThresholdPctReset;
      press_start_q <= '0;
      tap_time_q    <= '0;
    end else if (fire_i) begin
      pressing_q    <= pressing_d;
      tap_pending_q <= tap_pending_d;
      long_fired_q  <= long_fired_d;
      cal_active_q  <= cal_active_d;
      cal_count_q   <= cal_count_d;
      cal_sum_q     <= cal_sum_d;
      baseline_q    <= baseline_d;
      pct_q         <= pct_d;
      press_start_q <= press_start_d;
      tap_time_q    <= tap_time_d;
    end
  end

  assign result_o = res;

endmodule

// ===== rtl/touch_gesture_detector_top.sv =====
// Top level of the touch gesture detector: handshake registers, config and core.

// Touch gesture detector. Each sample transfer carries a reading and a
// millisecond timestamp and yields exactly one result transfer with tap,
// double tap and long press pulses, the touch flag, the calibration flag and
// the baseline. An item is held in the input register and is then evaluated
// by the core into the result register, so one item per cycle is sustained
// while the result side is not stalled; result valid rises when the item
// moves from the input register into the result register. The rate is set
// by the state feedback through the core (touch test multiplier, baseline
// update, calibration reciprocal multiply), which is combinational between
// the state registers. After reset and after a recalibrate item the first
// CAL_SAMPLES readings form the baseline. Configuration writes are taken in
// any cycle and should be made while no item is in flight.
module touch_gesture_detector_top #(
  parameter int unsigned CAL_SAMPLES = tgd_pkg::CalSamplesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgd_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [tgd_pkg::ReadingW-1:0]  raw_reading_i,
  input  logic [tgd_pkg::TimeW-1:0]     now_ms_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          tap_event_o,
  output logic                          double_tap_event_o,
  output logic                          long_press_event_o,
  output logic                          touched_now_o,
  output logic                          calibrating_now_o,
  output logic [tgd_pkg::ReadingW-1:0]  baseline_out_o
);

  `include "assert_macros.svh"

  tgd_pkg::cfg_t    cfg;
  tgd_pkg::item_t   item_q;
  tgd_pkg::result_t result, result_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  // Register file
  tgd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Item moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.req_type    <= req_type_i;
      item_q.raw_reading <= raw_reading_i;
      item_q.now_ms      <= now_ms_i;
    end
  end

  tgd_core #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tap_event_o        = result_q.tap_event;
  assign double_tap_event_o = result_q.double_tap_event;
  assign long_press_event_o = result_q.long_press_event;
  assign touched_now_o      = result_q.touched_now;
  assign calibrating_now_o  = result_q.calibrating_now;
  assign baseline_out_o     = result_q.baseline_out;

  // A double tap never coincides with a single tap or a long press
  `TGD_ASSERT(a_dbl_excl, out_valid_o |-> !(double_tap_event_o && (tap_event_o || long_press_event_o)), "double tap with other event")
  // Calibrating results carry no touch and no events
  `TGD_ASSERT(a_cal_quiet, (out_valid_o && calibrating_now_o) |-> !(touched_now_o || tap_event_o || double_tap_event_o || long_press_event_o), "activity while calibrating")
  // A held item with a free result side shows up as a result next cycle
  `TGD_ASSERT(a_item_moves, (in_valid_q && !out_stall_i) |=> out_valid_o, "item lost between stages")
  // Input side only stalls while an item waits behind a stalled result
  `TGD_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "spurious input stall")

endmodule

// ===== bench/touch_gesture_detector_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the touch gesture detector: gesture streams checked against a predictor.

import tgd_pkg::*;

// Tracks the detector's gesture and calibration state and holds the results it predicts
class gesture_tracker;
  localparam int unsigned MaxPrinted = 60;

  int unsigned cal_n;
  int unsigned mismatches;

  // register copies
  bit [PctW-1:0] pct;
  bit [MsW-1:0]  debounce;
  bit [MsW-1:0]  long_press;
  bit [MsW-1:0]  double_tap;

  // gesture and calibration state
  bit                pressing;
  bit                tap_pending;
  bit                long_fired;
  bit                cal_active;
  bit [ReadingW-1:0] baseline;
  bit [ReadingW-1:0] threshold;
  bit [TimeW-1:0]    press_start;
  bit [TimeW-1:0]    tap_time;
  int unsigned       cal_count;
  bit [CalSumW-1:0]  cal_sum;

  result_t pending_results[$];

  function new(int unsigned n);
    cal_n       = n;
    mismatches  = 0;
    pct         = ThresholdPctReset;
    debounce    = DebounceReset;
    long_press  = LongPressReset;
    double_tap  = DoubleTapReset;
    baseline    = '0;
    threshold   = '0;
    restart_calibration();
  endfunction

  function void restart_calibration();
    pressing    = 1'b0;
    press_start = '0;
    tap_pending = 1'b0;
    tap_time    = '0;
    long_fired  = 1'b0;
    cal_active  = 1'b1;
    cal_count   = 0;
    cal_sum     = '0;
  endfunction

  // threshold = baseline * percent / 100, saturated to the reading width
  function void refresh_threshold();
    bit [31:0] scaled;
    scaled = (32'(baseline) * 32'(pct)) / 32'(PctScale);
    threshold = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
  endfunction

  function void write_register(cfg_idx_e idx, bit [CfgDataW-1:0] data);
    case (idx)
      CfgThresholdPct: pct        = data[PctW-1:0];
      CfgDebounceMs:   debounce   = data;
      CfgLongPressMs:  long_press = data;
      CfgDoubleTapMs:  double_tap = data;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Advance the state by one accepted item and queue the result it causes
  function void accept_item(item_t it);
    result_t        want;
    bit             touched;
    bit [TimeW-1:0] held;
    bit [TimeW-1:0] since_tap;
    int             drift;
    want      = '0;
    touched   = 1'b0;
    held      = it.now_ms - press_start;
    since_tap = it.now_ms - tap_time;

    if (req_e'(it.req_type) == ReqRecal) begin
      restart_calibration();
    end else if (cal_active) begin
      // accumulate until the calibration set is complete
      cal_sum += CalSumW'(it.raw_reading);
      cal_count++;
      if (cal_count >= cal_n) begin
        baseline = ReadingW'(cal_sum / cal_n);
        refresh_threshold();
        cal_active = 1'b0;
        cal_count  = 0;
        cal_sum    = '0;
      end
    end else begin
      touched = it.raw_reading < threshold;

      // a lone tap is confirmed once its window has lapsed, only while untouched
      if (tap_pending && !touched && since_tap > 32'(double_tap)) begin
        want.tap_event = 1'b1;
        tap_pending    = 1'b0;
      end

      if (!pressing) begin
        if (touched) begin
          pressing    = 1'b1;
          press_start = it.now_ms;
        end else begin
          // idle drift: 1/16 of the signed difference, truncated toward zero
          drift    = (int'(it.raw_reading) - int'(baseline)) / 16;
          baseline = ReadingW'(int'(baseline) + drift);
          refresh_threshold();
        end
      end else if (!touched) begin
        // release
        if (long_fired) begin
          long_fired = 1'b0;
        end else if (held >= 32'(long_press)) begin
          want.long_press_event = 1'b1;
          tap_pending           = 1'b0;
        end else if (held >= 32'(debounce)) begin
          if (tap_pending && since_tap <= 32'(double_tap)) begin
            want.double_tap_event = 1'b1;
            tap_pending           = 1'b0;
          end else begin
            tap_pending = 1'b1;
            tap_time    = it.now_ms;
          end
        end
        pressing = 1'b0;
      end else if (held >= 32'(long_press) && !long_fired) begin
        // long press fires while still held
        want.long_press_event = 1'b1;
        long_fired            = 1'b1;
        tap_pending           = 1'b0;
      end
    end

    want.touched_now     = touched;
    want.calibrating_now = cal_active;
    want.baseline_out    = baseline;
    pending_results.push_back(want);
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", got, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.tap_event !== want.tap_event)
      report_mismatch("tap_event", got.tap_event, want.tap_event);
    if (got.double_tap_event !== want.double_tap_event)
      report_mismatch("double_tap_event", got.double_tap_event, want.double_tap_event);
    if (got.long_press_event !== want.long_press_event)
      report_mismatch("long_press_event", got.long_press_event, want.long_press_event);
    if (got.touched_now !== want.touched_now)
      report_mismatch("touched_now", got.touched_now, want.touched_now);
    if (got.calibrating_now !== want.calibrating_now)
      report_mismatch("calibrating_now", got.calibrating_now, want.calibrating_now);
    if (got.baseline_out !== want.baseline_out)
      report_mismatch("baseline_out", got.baseline_out, want.baseline_out);
  endtask
endclass

module touch_gesture_detector_top_tb;
  localparam int unsigned CalN          = CalSamplesDefault;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 225;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned WatchdogLimit = 5000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                req_type    = 1'b0;
  logic [ReadingW-1:0] raw_reading = '0;
  logic [TimeW-1:0]    now_ms      = '0;
  logic                out_stall   = 1'b0;

  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  logic                tap_event;
  logic                double_tap_event;
  logic                long_press_event;
  logic                touched_now;
  logic                calibrating_now;
  logic [ReadingW-1:0] baseline_out;

  gesture_tracker tracker;
  bit [TimeW-1:0]    now_t;
  bit [ReadingW-1:0] level;
  bit                sender_gaps;
  bit                hold_req;
  int unsigned       sent_count;

  always #6 clk = ~clk;

  touch_gesture_detector_top #(
    .CAL_SAMPLES(CalN)
  ) u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .raw_reading_i     (raw_reading),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .tap_event_o       (tap_event),
    .double_tap_event_o(double_tap_event),
    .long_press_event_o(long_press_event),
    .touched_now_o     (touched_now),
    .calibrating_now_o (calibrating_now),
    .baseline_out_o    (baseline_out)
  );

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and wait for its transfer
  task automatic send_item(req_e req, bit [ReadingW-1:0] reading, bit [TimeW-1:0] stamp);
    int unsigned gap;
    item_t       it;
    gap = sender_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    req_type    <= req;
    raw_reading <= reading;
    now_ms      <= stamp;
    do @(posedge clk); while (in_stall);
    it.req_type    = req;
    it.raw_reading = reading;
    it.now_ms      = stamp;
    tracker.accept_item(it);
    sent_count++;
  endtask

  task automatic write_register(cfg_idx_e idx, bit [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic bit [31:0] pick_in(bit [31:0] lo, bit [31:0] hi);
    if (hi <= lo) return lo;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // untouched reading near the sensor level, never below the current threshold
  function automatic bit [ReadingW-1:0] level_reading();
    int v;
    v = int'(level) + int'($urandom_range(0, 600)) - 300;
    if (v > 65535) v = 65535;
    if (v < int'(tracker.threshold)) v = int'(tracker.threshold);
    return v[15:0];
  endfunction

  function automatic bit [ReadingW-1:0] touch_reading();
    if (tracker.threshold == 0) return '0;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return tracker.threshold - 1'b1;
      default: return $urandom_range(0, tracker.threshold - 1'b1);
    endcase
  endfunction

  function automatic bit [31:0] tap_duration();
    if (tracker.debounce < tracker.long_press)
      return pick_in(tracker.debounce, 32'(tracker.long_press) - 1);
    return pick_in(tracker.debounce, 32'(tracker.debounce) + 100);
  endfunction

  task automatic calibrate(int unsigned n);
    repeat (n) begin
      now_t += $urandom_range(1, 40);
      send_item(ReqSample, level_reading(), now_t);
    end
  endtask

  task automatic idle_samples(int unsigned n);
    repeat (n) begin
      now_t += $urandom_range(1, 40);
      send_item(ReqSample, level_reading(), now_t);
    end
  endtask

  // Touch after lead ms, k held samples spread over the press, release after dur ms
  task automatic press(bit [31:0] dur, int unsigned k, bit [31:0] lead);
    bit [TimeW-1:0] start;
    now_t += lead;
    start = now_t;
    send_item(ReqSample, touch_reading(), start);
    for (int unsigned i = 1; i <= k; i++)
      send_item(ReqSample, touch_reading(), start + dur * i / (k + 1));
    now_t = start + dur;
    send_item(ReqSample, level_reading(), now_t);
  endtask

  // Samples around the end of the double tap window after a tap released at now_t
  task automatic lapse_window();
    bit [TimeW-1:0] released;
    released = now_t;
    now_t = released + tracker.double_tap;
    send_item(ReqSample, level_reading(), now_t);
    now_t = released + tracker.double_tap + 1 + $urandom_range(0, 20);
    send_item(ReqSample, level_reading(), now_t);
  endtask

  task automatic noise_items();
    bit [TimeW-1:0] stamp;
    repeat ($urandom_range(1, 3)) begin
      stamp = ($urandom_range(0, 3) == 0) ? $urandom : now_t + $urandom_range(0, 1000);
      now_t = stamp;
      send_item(($urandom_range(0, 15) == 0) ? ReqRecal : ReqSample, $urandom, stamp);
    end
  endtask

  task automatic random_gesture();
    int unsigned r;
    bit [31:0]   d2;
    bit [31:0]   lp;
    bit [31:0]   dt;
    lp = tracker.long_press;
    dt = tracker.double_tap;
    r  = $urandom_range(0, 99);
    if (r < 8) begin
      noise_items();
    end else if (r < 11) begin
      // recalibration, sometimes cut short by the gestures that follow
      send_item(ReqRecal, $urandom, now_t);
      calibrate($urandom_range(0, 1) ? CalN : $urandom_range(1, CalN));
    end else if (r < 20) begin
      idle_samples($urandom_range(1, 5));
    end else if (r < 35) begin
      // single tap left to expire
      press(tap_duration(), $urandom_range(0, 3), $urandom_range(1, 30));
      lapse_window();
    end else if (r < 50) begin
      // double tap, second release on either side of the window edge
      press(tap_duration(), $urandom_range(0, 2), $urandom_range(1, 30));
      d2 = tap_duration();
      press(d2, $urandom_range(0, 2), (dt > d2) ? pick_in(1, dt - d2 + 1) : 32'd1);
      if ($urandom_range(0, 1)) lapse_window();
    end else if (r < 60) begin
      // press shorter than the debounce time
      press((tracker.debounce == 0) ? 32'd0 : pick_in(0, 32'(tracker.debounce) - 1),
            $urandom_range(0, 2), $urandom_range(1, 30));
    end else if (r < 72) begin
      // long press held past the limit, then released
      press(2 * lp + $urandom_range(1, 500), $urandom_range(1, 4), $urandom_range(1, 30));
    end else if (r < 80) begin
      // long press noticed only at release
      press(pick_in(lp, lp + 200), 0, $urandom_range(1, 30));
    end else if (r < 90) begin
      // tap, then a touch inside the window holds off the tap report
      press(tap_duration(), 0, $urandom_range(1, 30));
      press(pick_in(0, dt + lp), $urandom_range(1, 3), 1);
    end else begin
      // press interrupted by a recalibration
      now_t += $urandom_range(1, 30);
      send_item(ReqSample, touch_reading(), now_t);
      send_item(ReqRecal, $urandom, now_t);
      calibrate(CalN);
    end
  endtask

  // Short directed pass: extremes, calibration, tap across the timestamp wrap,
  // window edge, short press and a held long press
  task automatic directed_items();
    send_item(ReqRecal, 16'hFFFF, 32'hFFFF_FFFF);
    now_t += 1;
    send_item(ReqSample, 16'hFFFF, now_t);
    now_t += 1;
    send_item(ReqSample, 16'h0000, now_t);
    calibrate(CalN - 2);
    now_t = 32'hFFFF_FFC0;
    press(120, 0, 1);
    lapse_window();
    press(32'(tracker.debounce) - 1, 0, 20);
    press(2 * 32'(tracker.long_press) + 100, 1, 20);
  endtask

  // ---------------------------------------------------------------- result side

  // Receiver stall pattern; a long hold on request lets the block fill up
  initial begin : result_stall
    bit          val;
    int unsigned n;
    int unsigned r;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        val      = 1'b1;
        n        = LongHold;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          val = 1'b0;
          n   = $urandom_range(1, 20);
        end else if (r < 90) begin
          val = 1'b1;
          n   = $urandom_range(1, 3);
        end else if (r < 97) begin
          val = 1'b0;
          n   = 1;
        end else begin
          val = 1'b1;
          n   = $urandom_range(10, 40);
        end
      end
      @(negedge clk);
      out_stall <= val;
      repeat (n - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.tap_event        = tap_event;
      got.double_tap_event = double_tap_event;
      got.long_press_event = long_press_event;
      got.touched_now      = touched_now;
      got.calibrating_now  = calibrating_now;
      got.baseline_out     = baseline_out;
      tracker.check_result(got);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : main_sequence
    bit [PctW-1:0] pct;
    bit [MsW-1:0]  deb;
    bit [MsW-1:0]  lp;
    bit [MsW-1:0]  dt;
    int unsigned   phase_end;
    bit            hold_done;
    tracker    = new(CalN);
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    sent_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      case (phase)
        0: begin pct = 80;  deb = 50;    lp = 800;   dt = 300;   end
        1: begin pct = 100; deb = 0;     lp = 65535; dt = 65535; end
        2: begin pct = 0;   deb = 65535; lp = 0;     dt = 0;     end
        3: begin pct = 127; deb = 10;    lp = 200;   dt = 100;   end
        4: begin pct = 60;  deb = 20;    lp = 0;     dt = 0;     end
        default: begin
          pct = $urandom_range(1, 100);
          deb = $urandom_range(0, 200);
          lp  = $urandom_range(2000, deb);
          dt  = $urandom_range(0, 1000);
        end
      endcase
      write_register(CfgThresholdPct, 16'(pct));
      write_register(CfgDebounceMs, deb);
      write_register(CfgLongPressMs, lp);
      write_register(CfgDoubleTapMs, dt);

      sender_gaps = (phase % 3 != 1);
      if (phase != 1)
        level = (pct > 100) ? 16'($urandom_range(52000, 65000)) : 16'($urandom_range(20000, 60000));
      now_t = (phase == 0 || phase == 3) ? 32'hFFFF_F000 : $urandom;

      // phase 1 keeps the old baseline so the new percent lands at the next drift step
      if (phase == 0) begin
        level = 40000;
        directed_items();
      end else if (phase != 1 && $urandom_range(0, 3) != 0) begin
        send_item(ReqRecal, $urandom, now_t);
        calibrate(CalN);
      end

      phase_end = sent_count + ItemsPerPhase;
      while (sent_count < phase_end) begin
        if (phase == 1 && !hold_done && sent_count + 150 > phase_end) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        random_gesture();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
